// ===== design/iis_pkg.sv =====
// Shared types and constants for the integer image scaler.
`default_nettype none
package iis_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [4:0]            SCALE_RESET  = 5'd0;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

  // Result field widths
  localparam int COORD_W = 16;
  localparam int SPAN_W  = 4;
  localparam int PIXEL_W = 32;
  // Run count per source pixel; holds scale counts up to 31
  localparam int CNT_W   = 5;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // One queued command: a group of runs that a source pixel causes
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SPAN_W-1:0]  span;
    logic [CNT_W-1:0]   count;
    logic [PIXEL_W-1:0] pixel;
  } run_cmd_t;

endpackage
`default_nettype wire

// ===== design/iis_pixel_if.sv =====
// Source pixel channel.
`default_nettype none
interface iis_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;

  modport source (output valid, output pixel_rgba, input ready);
  modport sink   (input valid, input pixel_rgba, output ready);
endinterface
`default_nettype wire

// ===== design/iis_run_if.sv =====
// Output run channel.
`default_nettype none
interface iis_run_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_row;
  logic [15:0] out_col;
  logic [3:0]  run_span;
  logic [31:0] out_pixel;
  logic        run_last;

  modport source (output valid, output out_row, output out_col, output run_span,
                  output out_pixel, output run_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input run_span,
                  input out_pixel, input run_last, output ready);
endinterface
`default_nettype wire

// ===== design/iis_front.sv =====
// Front end: configuration, source position counters and pixel classification.
`default_nettype none
module iis_front #(
  parameter int MAX_SCALE = 10,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [iis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [iis_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  iis_pixel_if.sink                              pix_in,
  output logic                                   push,
  output iis_pkg::run_cmd_t                      entry,
  input  wire logic                              full
);

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int SCALE_W = $clog2(MAX_SCALE + 1);
  localparam int CW      = (DIM_W + 1 > iis_pkg::CFG_DATA_W) ? DIM_W + 1
                                                              : iis_pkg::CFG_DATA_W;
  localparam int PW      = DIM_W + SCALE_W;
  localparam int RW      = 2 * DIM_W;

  typedef enum logic [1:0] {MODE_PASS, MODE_UP, MODE_DOWN} mode_t;

  // Configuration registers
  logic [4:0]                       scale_factor;
  logic [iis_pkg::CFG_DATA_W-1:0]   image_width;
  logic [iis_pkg::CFG_DATA_W-1:0]   image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= iis_pkg::SCALE_RESET;
      image_width  <= iis_pkg::WIDTH_RESET;
      image_height <= iis_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        iis_pkg::REG_SCALE:  scale_factor <= cfg_wdata[4:0];
        iis_pkg::REG_WIDTH:  image_width  <= cfg_wdata;
        iis_pkg::REG_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped dimensions and scale magnitude
  logic [CW-1:0]      w_ext, h_ext, w_eff, h_eff;
  logic [4:0]         mag_raw, mag_sat;
  logic [SCALE_W-1:0] mag;
  mode_t              mode;

  always_comb begin
    w_ext = CW'(image_width);
    h_ext = CW'(image_height);
    if (w_ext == '0)             w_eff = CW'(1);
    else if (w_ext > CW'(MAX_DIM)) w_eff = CW'(MAX_DIM);
    else                         w_eff = w_ext;
    if (h_ext == '0)             h_eff = CW'(1);
    else if (h_ext > CW'(MAX_DIM)) h_eff = CW'(MAX_DIM);
    else                         h_eff = h_ext;

    mag_raw = scale_factor[4] ? 5'(~scale_factor + 5'd1) : scale_factor;
    mag_sat = (mag_raw > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : mag_raw;
    mag     = SCALE_W'(mag_sat);

    if (mag <= SCALE_W'(1))   mode = MODE_PASS;
    else if (!scale_factor[4]) mode = MODE_UP;
    else                      mode = MODE_DOWN;
  end

  // Reciprocal table: ceil(2^DIM_W / m), exact quotient for multiples of m
  logic [DIM_W-1:0] recip_tab [MAX_SCALE+1];

  for (genvar Gm = 0; Gm <= MAX_SCALE; Gm++) begin : g_recip
    if (Gm < 2) begin : g_unused
      assign recip_tab[Gm] = '0;
    end else begin : g_val
      localparam int RV = ((1 << DIM_W) + Gm - 1) / Gm;
      assign recip_tab[Gm] = DIM_W'(RV);
    end
  end

  // Source position counters
  logic [DIM_W-1:0] src_col, src_row;
  logic             accept;

  // Stage A: classified item
  logic               a_valid;
  mode_t              a_mode;
  logic [31:0]        a_pixel;
  logic [DIM_W-1:0]   a_col, a_row;
  logic [SCALE_W-1:0] a_mag;
  logic               a_fit;
  logic [PW-1:0]      a_up_col, a_up_row;
  logic [DIM_W-1:0]   a_qc, a_qr;

  logic [RW-1:0]      prod_qc, prod_qr;
  logic               need, a_adv, div_ok;

  assign prod_qc = RW'(src_col) * RW'(recip_tab[mag]);
  assign prod_qr = RW'(src_row) * RW'(recip_tab[mag]);

  assign div_ok = (PW'(a_qc) * PW'(a_mag) == PW'(a_col)) &&
                  (PW'(a_qr) * PW'(a_mag) == PW'(a_row));

  always_comb begin
    need  = 1'b1;
    entry = '0;
    entry.pixel = a_pixel;
    unique case (a_mode)
      MODE_PASS: begin
        entry.row   = iis_pkg::COORD_W'(a_row);
        entry.col   = iis_pkg::COORD_W'(a_col);
        entry.span  = iis_pkg::SPAN_W'(1);
        entry.count = iis_pkg::CNT_W'(1);
      end
      MODE_UP: begin
        entry.row   = iis_pkg::COORD_W'(a_up_row);
        entry.col   = iis_pkg::COORD_W'(a_up_col);
        entry.span  = iis_pkg::SPAN_W'(a_mag);
        entry.count = iis_pkg::CNT_W'(a_mag);
      end
      MODE_DOWN: begin
        entry.row   = iis_pkg::COORD_W'(a_qr);
        entry.col   = iis_pkg::COORD_W'(a_qc);
        entry.span  = iis_pkg::SPAN_W'(1);
        entry.count = iis_pkg::CNT_W'(1);
        need        = div_ok && a_fit;
      end
      default: need = 1'b0;
    endcase
  end

  // Drop a skipped pixel without waiting for queue space
  assign a_adv        = a_valid && (!need || !full);
  assign push         = a_valid && need && !full;
  assign pix_in.ready = !a_valid || a_adv;
  assign accept       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      src_col <= '0;
      src_row <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (CW'(src_col) + CW'(1) >= w_eff) begin
          src_col <= '0;
          src_row <= (CW'(src_row) + CW'(1) >= h_eff) ? '0 : src_row + DIM_W'(1);
        end else begin
          src_col <= src_col + DIM_W'(1);
        end
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode   <= mode;
      a_pixel  <= pix_in.pixel_rgba;
      a_col    <= src_col;
      a_row    <= src_row;
      a_mag    <= mag;
      a_fit    <= (CW'(src_col) + CW'(mag) <= w_eff) &&
                  (CW'(src_row) + CW'(mag) <= h_eff);
      a_up_col <= PW'(src_col) * PW'(mag);
      a_up_row <= PW'(src_row) * PW'(mag);
      a_qc     <= prod_qc[RW-1:DIM_W];
      a_qr     <= prod_qr[RW-1:DIM_W];
    end
  end

endmodule
`default_nettype wire

// ===== design/iis_queue.sv =====
// Short command queue between the front and back ends.
`default_nettype none
module iis_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire iis_pkg::run_cmd_t  wdata,
  output logic                    full,
  input  wire logic               pop,
  output iis_pkg::run_cmd_t       rdata,
  output logic                    empty
);

  localparam int DEPTH = iis_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  iis_pkg::run_cmd_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop)      fill <= fill + CNT_W'(1);
      else if (pop && !push) fill <= fill - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule
`default_nettype wire

// ===== design/iis_back.sv =====
// Back end: expands a command into runs in the output register, one per unstalled cycle.
`default_nettype none
module iis_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iis_pkg::run_cmd_t  head,
  input  wire logic               empty,
  output logic                    pop,
  iis_run_if.source               run_out
);

  logic [iis_pkg::CNT_W-1:0] run_idx;
  logic                      load, last;

  assign load = !empty && (!run_out.valid || run_out.ready);
  assign last = (run_idx + iis_pkg::CNT_W'(1) == head.count);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_out.valid <= 1'b0;
      run_idx       <= '0;
    end else if (load) begin
      run_out.valid <= 1'b1;
      run_idx       <= last ? '0 : run_idx + iis_pkg::CNT_W'(1);
    end else if (run_out.ready) begin
      run_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_out.out_row   <= head.row + iis_pkg::COORD_W'(run_idx);
      run_out.out_col   <= head.col;
      run_out.run_span  <= head.span;
      run_out.out_pixel <= head.pixel;
      run_out.run_last  <= last;
    end
  end

endmodule
`default_nettype wire

// ===== design/integer_image_scaler_unit.sv =====
// Top level of the nearest-neighbor integer image scaler.
//
// Pixels of a frame arrive in raster order on pix_in; the block counts the
// source column and row itself and wraps them at the configured width and
// height. With scale s > 1 each pixel becomes s runs (one per replicated
// output row) starting at column x*s and spanning s pixels; with scale -s a
// pixel is kept only when its column and row are multiples of s and it lies
// inside the truncated output size, and it yields one run of span 1. Scales
// 0, 1 and -1 pass pixels through. A pass-through or shrinking pixel yields
// one run and an enlarging pixel yields s runs; the output register issues
// one run per cycle while run_out.ready allows. An accepted pixel loads the
// classify stage (position products), then is written to a queue slot, and
// its runs are loaded in turn into the output register. A four-entry queue
// lets the front keep taking pixels while the back stalls on run_out.ready.
// Write configuration only while no pixel is in flight.
`default_nettype none
module integer_image_scaler_unit #(
  parameter int MAX_SCALE = 10,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [iis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [iis_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  iis_pixel_if.sink                             pix_in,
  iis_run_if.source                             run_out
);

  // Front to queue
  logic              q_push, q_full;
  iis_pkg::run_cmd_t q_wdata;

  // Queue to back
  logic              q_pop, q_empty;
  iis_pkg::run_cmd_t q_head;

  // Classify pixels and hold the frame position
  iis_front #(
    .MAX_SCALE (MAX_SCALE),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix_in    (pix_in),
    .push      (q_push),
    .entry     (q_wdata),
    .full      (q_full)
  );

  // Decouple classification from run issue
  iis_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // Expand each command into its runs
  iis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .empty   (q_empty),
    .pop     (q_pop),
    .run_out (run_out)
  );

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Never drain an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A completed command leaves a run marked last in the output register
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> run_out.valid && run_out.run_last)
    else $error("command retired without a last run");

endmodule
`default_nettype wire
